FILE: hw/rtl/i2cmbe_pkg.sv
// Shared constants, codes and types of the I2C master byte engine.
package i2cmbe_pkg;

  localparam int unsigned PhaseW   = 16;
  localparam int unsigned TimeoutW = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [PhaseW-1:0]   PHASE_TICKS_RST   = 16'd100;
  localparam logic [TimeoutW-1:0] TIMEOUT_LIMIT_RST = 8'd250;
  localparam logic [3:0]          BITS_PER_BYTE     = 4'd8;

  // Register indexes, taken from paddr[2].
  localparam logic REG_PHASE_TICKS   = 1'b0;
  localparam logic REG_TIMEOUT_LIMIT = 1'b1;

  // Command codes on the op field.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  typedef struct packed {
    logic [PhaseW-1:0]   phase_ticks;
    logic [TimeoutW-1:0] timeout_limit;
  } cfg_t;

endpackage

FILE: hw/rtl/i2cmbe_if.sv
// Valid/ready channel interfaces for ticks in and bus results out.
interface i2cmbe_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] op;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_sample;

  modport source (output valid, cmd_valid, op, tx_byte, send_ack, sda_sample, input ready);
  modport sink (input valid, cmd_valid, op, tx_byte, send_ack, sda_sample, output ready);
endinterface

interface i2cmbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte, ack_error,
                  input ready);
  modport sink (input valid, scl_level, sda_level, busy_res, done_res, rx_byte, ack_error,
                output ready);
endinterface

FILE: hw/rtl/i2cmbe_cfg.sv
// APB register file holding the bus phase length and the acknowledge timeout.
module i2cmbe_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cmbe_pkg::AddrW-1:0] paddr,
  input  logic [i2cmbe_pkg::DataW-1:0] pwdata,
  output logic [i2cmbe_pkg::DataW-1:0] prdata,
  output logic                         pready,
  output i2cmbe_pkg::cfg_t             cfg_o
);

  i2cmbe_pkg::cfg_t cfg_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks   <= i2cmbe_pkg::PHASE_TICKS_RST;
      cfg_q.timeout_limit <= i2cmbe_pkg::TIMEOUT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        i2cmbe_pkg::REG_PHASE_TICKS: begin
          cfg_q.phase_ticks <= pwdata[i2cmbe_pkg::PhaseW-1:0];
        end
        default: begin
          cfg_q.timeout_limit <= pwdata[i2cmbe_pkg::TimeoutW-1:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      i2cmbe_pkg::REG_PHASE_TICKS: begin
        prdata = {{(i2cmbe_pkg::DataW - i2cmbe_pkg::PhaseW){1'b0}}, cfg_q.phase_ticks};
      end
      default: begin
        prdata = {{(i2cmbe_pkg::DataW - i2cmbe_pkg::TimeoutW){1'b0}}, cfg_q.timeout_limit};
      end
    endcase
  end

endmodule

FILE: hw/rtl/i2c_master_byte_engine.sv
// Top level of the I2C master byte engine: command sequencer and result register.
// The result of a tick is written into the output register at the clock edge of its transfer.
// Throughput: one tick per cycle; the input stalls only while a held result is not taken.
// Each tick updates the sequencer state and the result register in the same clock edge.
// Reset (rst_ni low, asynchronous) idles the sequencer, releases SCL and SDA, and loads
// the register defaults of 100 ticks per phase and an acknowledge timeout of 250.
module i2c_master_byte_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  i2cmbe_tick_if.sink                  tick_i,
  i2cmbe_res_if.source                 res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cmbe_pkg::AddrW-1:0] paddr,
  input  logic [i2cmbe_pkg::DataW-1:0] pwdata,
  output logic [i2cmbe_pkg::DataW-1:0] prdata,
  output logic                         pready
);

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  i2cmbe_pkg::cfg_t cfg;

  cmd_e                          cmd_q, cmd_d;
  logic [1:0]                    ps_q, ps_d;
  logic [3:0]                    bc_q, bc_d;
  logic [7:0]                    shift_q, shift_d;
  logic [i2cmbe_pkg::PhaseW-1:0] div_q, div_d;
  logic [7:0]                    wait_q, wait_d;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic                          ack_q, ack_d;
  logic                          err_q, err_d;

  logic                          res_valid_q;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic                          accept;
  logic                          enter;
  logic [i2cmbe_pkg::PhaseW-1:0] pt;

  i2cmbe_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign tick_i.ready = !res_valid_q || res_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;
  assign pt = (cfg.phase_ticks == '0) ? {{(i2cmbe_pkg::PhaseW-1){1'b0}}, 1'b1} : cfg.phase_ticks;

  // SCL and SDA levels of a phase.
  function automatic logic [1:0] phase_levels(cmd_e cmd, logic [1:0] ps, logic [3:0] bc,
                                              logic [7:0] shift, logic ack, logic [1:0] cur);
    logic [1:0] lv;
    lv = cur;
    unique case (cmd)
      CMD_START: begin
        if (ps == 2'd0) lv = 2'b11;
        else if (ps == 2'd1) lv = 2'b10;
        else lv = 2'b00;
      end
      CMD_STOP: begin
        if (ps == 2'd0) lv = 2'b00;
        else if (ps == 2'd1) lv = 2'b10;
        else lv = 2'b11;
      end
      CMD_WRITE: begin
        if (bc < i2cmbe_pkg::BITS_PER_BYTE) lv = {ps == 2'd1, shift[7]};
        else if (ps == 2'd0 || ps == 2'd3) lv = 2'b01;
        else lv = 2'b11;
      end
      CMD_READ: begin
        if (bc < i2cmbe_pkg::BITS_PER_BYTE) lv = {ps == 2'd1, 1'b1};
        else lv = {ps == 2'd1, !ack};
      end
      default: begin
        lv = cur;
      end
    endcase
    return lv;
  endfunction

  always_comb begin
    cmd_d   = cmd_q;
    ps_d    = ps_q;
    bc_d    = bc_q;
    shift_d = shift_q;
    div_d   = div_q;
    wait_d  = wait_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    err_d   = err_q;
    busy_d  = 1'b0;
    done_d  = 1'b0;
    enter   = 1'b0;

    if (cmd_q == CMD_IDLE) begin
      if (tick_i.cmd_valid) begin
        busy_d = 1'b1;
        ps_d   = 2'd0;
        bc_d   = 4'd0;
        enter  = 1'b1;
        unique case (tick_i.op)
          i2cmbe_pkg::OP_START: begin
            cmd_d = CMD_START;
          end
          i2cmbe_pkg::OP_STOP: begin
            cmd_d = CMD_STOP;
          end
          i2cmbe_pkg::OP_WRITE: begin
            cmd_d   = CMD_WRITE;
            shift_d = tick_i.tx_byte;
            err_d   = 1'b0;
          end
          default: begin
            cmd_d   = CMD_READ;
            shift_d = 8'd0;
            ack_d   = tick_i.send_ack;
          end
        endcase
      end
    end else begin
      busy_d = 1'b1;
      if (cmd_q == CMD_WRITE && bc_q >= i2cmbe_pkg::BITS_PER_BYTE && ps_q == 2'd2) begin
        // Acknowledge poll.
        if (!tick_i.sda_sample) begin
          ps_d  = 2'd3;
          enter = 1'b1;
        end else if (wait_q >= cfg.timeout_limit) begin
          err_d = 1'b1;
          cmd_d = CMD_STOP;
          ps_d  = 2'd0;
          enter = 1'b1;
        end else begin
          wait_d = wait_q + 8'd1;
        end
      end else if (div_q >= pt) begin
        unique case (cmd_q)
          CMD_START, CMD_STOP: begin
            ps_d = ps_q + 2'd1;
            if (ps_q == 2'd2) done_d = 1'b1;
            else enter = 1'b1;
          end
          CMD_WRITE: begin
            if (bc_q < i2cmbe_pkg::BITS_PER_BYTE) begin
              if (ps_q == 2'd2) begin
                shift_d = {shift_q[6:0], 1'b0};
                ps_d    = 2'd0;
                bc_d    = bc_q + 4'd1;
              end else begin
                ps_d = ps_q + 2'd1;
              end
              enter = 1'b1;
            end else if (ps_q == 2'd3) begin
              done_d = 1'b1;
            end else begin
              ps_d = ps_q + 2'd1;
              if (ps_q == 2'd1) wait_d = 8'd0;
              enter = 1'b1;
            end
          end
          CMD_READ: begin
            if (bc_q < i2cmbe_pkg::BITS_PER_BYTE) begin
              if (ps_q == 2'd1) shift_d = {shift_q[6:0], tick_i.sda_sample};
              if (ps_q >= 2'd2) begin
                ps_d = 2'd0;
                bc_d = bc_q + 4'd1;
              end else begin
                ps_d = ps_q + 2'd1;
              end
              enter = 1'b1;
            end else begin
              ps_d = ps_q + 2'd1;
              if (ps_q >= 2'd2) done_d = 1'b1;
              else enter = 1'b1;
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end else begin
        div_d = div_q + {{(i2cmbe_pkg::PhaseW-1){1'b0}}, 1'b1};
      end

      if (done_d) begin
        cmd_d = CMD_IDLE;
        ps_d  = 2'd0;
        bc_d  = 4'd0;
        div_d = '0;
      end
    end

    if (enter) begin
      div_d = {{(i2cmbe_pkg::PhaseW-1){1'b0}}, 1'b1};
      {scl_d, sda_d} = phase_levels(cmd_d, ps_d, bc_d, shift_d, ack_d, {scl_q, sda_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_IDLE;
      ps_q        <= 2'd0;
      bc_q        <= 4'd0;
      shift_q     <= 8'd0;
      div_q       <= '0;
      wait_q      <= 8'd0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b0;
      err_q       <= 1'b0;
      res_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (accept) begin
        cmd_q       <= cmd_d;
        ps_q        <= ps_d;
        bc_q        <= bc_d;
        shift_q     <= shift_d;
        div_q       <= div_d;
        wait_q      <= wait_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        ack_q       <= ack_d;
        err_q       <= err_d;
        busy_q      <= busy_d;
        done_q      <= done_d;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.scl_level = scl_q;
  assign res_o.sda_level = sda_q;
  assign res_o.busy_res  = busy_q;
  assign res_o.done_res  = done_q;
  assign res_o.rx_byte   = shift_q;
  assign res_o.ack_error = err_q;

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= i2cmbe_pkg::BITS_PER_BYTE)
    else $error("bit count beyond one byte");

  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q == CMD_IDLE |-> (div_q == '0 && ps_q == 2'd0 && bc_q == 4'd0))
    else $error("idle sequencer with live phase state");

  a_done_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && done_q |-> cmd_q == CMD_IDLE && busy_q)
    else $error("completion reported while a command is still running");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(cmd_q) && $stable(div_q) && $stable(shift_q))
    else $error("sequencer state moved without a tick transfer");

endmodule
